// ===== hdl/cte_pkg.sv =====
// cte_pkg: shared types and codes for the csr transpose engine
// beat payload structs, command and status codes, default sizes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cte_pkg;

	localparam int MAX_NODES_DEF = 1024;
	localparam int MAX_EDGES_DEF = 4096;

	localparam int CMD_W   = 3;
	localparam int NODE_FW = 10;
	localparam int IDX_W   = 13;
	localparam int ST_W    = 2;
	localparam int RS_FW   = 13;
	localparam int EID_FW  = 12;
	localparam int NC_W    = 11;

	localparam logic [NC_W-1:0] NODE_TOTAL_RST = 11'd1024;

	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FINISH = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ROW    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ENTRY  = 3'd4;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
	localparam logic [ST_W-1:0] ST_BAD   = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [NODE_FW-1:0] dest_node;
		logic [NODE_FW-1:0] src_node;
		logic [IDX_W-1:0]   read_index;
	} cte_in_t;

	typedef struct packed {
		logic [ST_W-1:0]    status;
		logic [RS_FW-1:0]   row_start;
		logic [NODE_FW-1:0] target_node;
		logic [EID_FW-1:0]  edge_index;
	} cte_out_t;

endpackage

`default_nettype wire

// ===== hdl/cte_ram.sv =====
// cte_ram: simple dual-port memory, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module cte_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 13
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/csr_transpose_engine_unit.sv =====
// csr_transpose_engine_unit: top level of the csr transpose engine
// depends on cte_pkg and cte_ram
//
// Transposes an incoming-edge CSR graph into outgoing rows by a counting sort on the source
// node. One command beat is taken at a time and gives one result beat. After reset, and after
// every clear command, a sweep zeroes all MAX_NODES+1 row start entries while no beat is
// accepted (node total writes are taken at any time). A load runs execute, load write and
// response states, a read execute, read wait and response, a refused command execute and
// response; the result is then registered and the engine returns to idle. A finish runs a
// prefix pass that reads, then rewrites each row start, and a scatter pass that reads an edge,
// its fill cursor, then writes the entry, both paced by the single read and write port of each
// memory. A new beat is taken while the previous result still waits on the output register.
`timescale 1ns / 1ps
`default_nettype none

module csr_transpose_engine_unit import cte_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int MAX_EDGES = MAX_EDGES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire cte_in_t         in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output cte_out_t             out_data,
	input  wire logic            cfg_wr_en,
	input  wire logic [NC_W-1:0] cfg_wr_data
);

	localparam int NODE_W   = $clog2(MAX_NODES);
	localparam int EDGE_W   = $clog2(MAX_EDGES);
	localparam int CNT_W    = $clog2(MAX_EDGES + 1);
	localparam int RS_DEPTH = MAX_NODES + 1;
	localparam int RS_AW    = $clog2(RS_DEPTH);
	localparam int PTR_W    = (RS_AW > CNT_W) ? RS_AW : CNT_W;
	localparam int ES_W     = NODE_FW + NODE_W;
	localparam int OS_W     = NODE_FW + EDGE_W;

	typedef enum logic [10:0] {
		S_CLR   = 11'b000_0000_0001,
		S_IDLE  = 11'b000_0000_0010,
		S_EXEC  = 11'b000_0000_0100,
		S_LDWR  = 11'b000_0000_1000,
		S_PFXRD = 11'b000_0001_0000,
		S_PFXWR = 11'b000_0010_0000,
		S_SCE   = 11'b000_0100_0000,
		S_SCF   = 11'b000_1000_0000,
		S_SCW   = 11'b001_0000_0000,
		S_RDWT  = 11'b010_0000_0000,
		S_RESP  = 11'b100_0000_0000
	} cte_state_t;

	cte_state_t          state_q;
	cte_in_t             item_q;
	cte_out_t            res_q;
	cte_out_t            out_q;
	logic                out_valid_q;
	logic [NC_W-1:0]     nodes_cfg_q;
	logic [CNT_W-1:0]    edges_q;
	logic                fin_q;
	logic                resp_pend_q;
	logic [PTR_W-1:0]    ptr_q;
	logic [CNT_W-1:0]    acc_q;
	logic [NODE_W-1:0]   esrc_q;
	logic [NODE_FW-1:0]  edest_q;

	// memory ports
	logic                rs_we;
	logic [RS_AW-1:0]    rs_waddr, rs_raddr;
	logic [CNT_W-1:0]    rs_wdata, rs_rdata;
	logic                fc_we;
	logic [NODE_W-1:0]   fc_waddr, fc_raddr;
	logic [CNT_W-1:0]    fc_wdata, fc_rdata;
	logic                es_we;
	logic [EDGE_W-1:0]   es_waddr, es_raddr;
	logic [ES_W-1:0]     es_wdata, es_rdata;
	logic                os_we;
	logic [EDGE_W-1:0]   os_waddr, os_raddr;
	logic [OS_W-1:0]     os_wdata, os_rdata;

	// decode of the held beat
	logic [31:0] n32, dest32, src32, srcp1, idx32, edges32, ptr32, ptrp1;
	logic        load_range_bad, load_full, row_bad, entry_bad;
	logic [ST_W-1:0] exec_st;

	always_comb begin
		if (nodes_cfg_q == '0) begin
			n32 = 32'd1;
		end else if (32'(nodes_cfg_q) > 32'(MAX_NODES)) begin
			n32 = 32'(MAX_NODES);
		end else begin
			n32 = 32'(nodes_cfg_q);
		end
		dest32  = 32'(item_q.dest_node);
		src32   = 32'(item_q.src_node);
		srcp1   = src32 + 32'd1;
		idx32   = 32'(item_q.read_index);
		edges32 = 32'(edges_q);
		ptr32   = 32'(ptr_q);
		ptrp1   = ptr32 + 32'd1;
		load_range_bad = (dest32 >= n32) || (src32 >= n32);
		load_full      = edges32 >= 32'(MAX_EDGES);
		row_bad        = !fin_q || (idx32 > n32);
		entry_bad      = !fin_q || (idx32 >= edges32);
		exec_st = ST_OK;
		unique case (item_q.command)
			CMD_CLEAR: begin
				exec_st = ST_OK;
			end
			CMD_FINISH: begin
				exec_st = ST_OK;
			end
			CMD_LOAD: begin
				if (fin_q) begin
					exec_st = ST_BAD;
				end else if (load_range_bad) begin
					exec_st = ST_RANGE;
				end else if (load_full) begin
					exec_st = ST_FULL;
				end
			end
			CMD_ROW: begin
				if (row_bad) begin
					exec_st = ST_BAD;
				end
			end
			CMD_ENTRY: begin
				if (entry_bad) begin
					exec_st = ST_BAD;
				end
			end
			default: begin
				exec_st = ST_BAD;
			end
		endcase
	end

	always_comb begin
		rs_we    = 1'b0;
		rs_waddr = '0;
		rs_wdata = '0;
		rs_raddr = '0;
		fc_we    = 1'b0;
		fc_waddr = '0;
		fc_wdata = '0;
		fc_raddr = '0;
		es_we    = 1'b0;
		es_waddr = edges_q[EDGE_W-1:0];
		es_wdata = {item_q.dest_node, src32[NODE_W-1:0]};
		es_raddr = ptr_q[EDGE_W-1:0];
		os_we    = 1'b0;
		os_waddr = fc_rdata[EDGE_W-1:0];
		os_wdata = {edest_q, ptr_q[EDGE_W-1:0]};
		os_raddr = idx32[EDGE_W-1:0];
		case (state_q)
			S_CLR: begin
				rs_we    = 1'b1;
				rs_waddr = ptr_q[RS_AW-1:0];
			end
			S_EXEC: begin
				if (item_q.command == CMD_LOAD) begin
					rs_raddr = srcp1[RS_AW-1:0];
					es_we    = !fin_q && !load_range_bad && !load_full;
				end else begin
					rs_raddr = idx32[RS_AW-1:0];
				end
			end
			S_LDWR: begin
				rs_we    = 1'b1;
				rs_waddr = srcp1[RS_AW-1:0];
				rs_wdata = rs_rdata + CNT_W'(1);
			end
			S_PFXRD: begin
				rs_raddr = ptrp1[RS_AW-1:0];
			end
			S_PFXWR: begin
				rs_we    = 1'b1;
				rs_waddr = ptrp1[RS_AW-1:0];
				rs_wdata = acc_q + rs_rdata;
				fc_we    = 1'b1;
				fc_waddr = ptr_q[NODE_W-1:0];
				fc_wdata = acc_q;
			end
			S_SCF: begin
				fc_raddr = es_rdata[NODE_W-1:0];
			end
			S_SCW: begin
				fc_we    = 1'b1;
				fc_waddr = esrc_q;
				fc_wdata = fc_rdata + CNT_W'(1);
				os_we    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	cte_ram #(.DEPTH(RS_DEPTH), .WIDTH(CNT_W)) u_rs_ram (
		.clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
		.raddr(rs_raddr), .rdata(rs_rdata)
	);

	cte_ram #(.DEPTH(MAX_NODES), .WIDTH(CNT_W)) u_fc_ram (
		.clk(clk), .we(fc_we), .waddr(fc_waddr), .wdata(fc_wdata),
		.raddr(fc_raddr), .rdata(fc_rdata)
	);

	cte_ram #(.DEPTH(MAX_EDGES), .WIDTH(ES_W)) u_es_ram (
		.clk(clk), .we(es_we), .waddr(es_waddr), .wdata(es_wdata),
		.raddr(es_raddr), .rdata(es_rdata)
	);

	cte_ram #(.DEPTH(MAX_EDGES), .WIDTH(OS_W)) u_os_ram (
		.clk(clk), .we(os_we), .waddr(os_waddr), .wdata(os_wdata),
		.raddr(os_raddr), .rdata(os_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			edges_q     <= '0;
			fin_q       <= 1'b0;
			resp_pend_q <= 1'b0;
			ptr_q       <= '0;
			acc_q       <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					if (ptr_q == PTR_W'(RS_DEPTH - 1)) begin
						ptr_q <= '0;
						if (resp_pend_q) begin
							state_q <= S_RESP;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						ptr_q <= ptr_q + PTR_W'(1);
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (item_q.command)
						CMD_CLEAR: begin
							edges_q     <= '0;
							fin_q       <= 1'b0;
							ptr_q       <= '0;
							resp_pend_q <= 1'b1;
							state_q     <= S_CLR;
						end
						CMD_LOAD: begin
							if (!fin_q && !load_range_bad && !load_full) begin
								edges_q <= edges_q + CNT_W'(1);
								state_q <= S_LDWR;
							end else begin
								state_q <= S_RESP;
							end
						end
						CMD_FINISH: begin
							if (!fin_q) begin
								ptr_q   <= '0;
								acc_q   <= '0;
								state_q <= S_PFXRD;
							end else begin
								state_q <= S_RESP;
							end
						end
						CMD_ROW: begin
							if (!row_bad) begin
								state_q <= S_RDWT;
							end else begin
								state_q <= S_RESP;
							end
						end
						CMD_ENTRY: begin
							if (!entry_bad) begin
								state_q <= S_RDWT;
							end else begin
								state_q <= S_RESP;
							end
						end
						default: begin
							state_q <= S_RESP;
						end
					endcase
				end
				S_LDWR: begin
					state_q <= S_RESP;
				end
				S_PFXRD: begin
					state_q <= S_PFXWR;
				end
				S_PFXWR: begin
					acc_q <= acc_q + rs_rdata;
					if (ptr_q == PTR_W'(MAX_NODES - 1)) begin
						ptr_q <= '0;
						if (edges_q == '0) begin
							fin_q   <= 1'b1;
							state_q <= S_RESP;
						end else begin
							state_q <= S_SCE;
						end
					end else begin
						ptr_q   <= ptr_q + PTR_W'(1);
						state_q <= S_PFXRD;
					end
				end
				S_SCE: begin
					state_q <= S_SCF;
				end
				S_SCF: begin
					state_q <= S_SCW;
				end
				S_SCW: begin
					if (ptrp1 == edges32) begin
						fin_q   <= 1'b1;
						state_q <= S_RESP;
					end else begin
						ptr_q   <= ptr_q + PTR_W'(1);
						state_q <= S_SCE;
					end
				end
				S_RDWT: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						resp_pend_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// held beat and result assembly
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			item_q <= in_data;
		end
		if (state_q == S_SCF) begin
			edest_q <= es_rdata[ES_W-1 -: NODE_FW];
			esrc_q  <= es_rdata[NODE_W-1:0];
		end
		if (state_q == S_EXEC) begin
			res_q <= cte_out_t'{status: exec_st, default: '0};
		end
		if (state_q == S_RDWT) begin
			if (item_q.command == CMD_ROW) begin
				res_q.row_start <= RS_FW'(rs_rdata);
			end else begin
				res_q.target_node <= os_rdata[OS_W-1 -: NODE_FW];
				res_q.edge_index  <= EID_FW'(os_rdata[EDGE_W-1:0]);
			end
		end
		if (state_q == S_CLR && resp_pend_q) begin
			res_q <= '0;
		end
		if (state_q == S_RESP && (!out_valid_q || out_ready)) begin
			out_q <= res_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RESP && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// node total register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_cfg_q <= NODE_TOTAL_RST;
		end else if (cfg_wr_en) begin
			nodes_cfg_q <= cfg_wr_data;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ===== hdl/cte_checker.sv =====
// cte_checker: port-level checks for csr_transpose_engine_unit, bound to the top level
// depends on cte_pkg and csr_transpose_engine_unit
`timescale 1ns / 1ps
`default_nettype none

module cte_checker import cte_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_valid,
	input wire logic     in_ready,
	input wire cte_in_t  in_data,
	input wire logic     out_valid,
	input wire logic     out_ready,
	input wire cte_out_t out_data
);

	// beats taken but not yet answered
	logic [1:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after a command beat");

	a_error_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |->
		out_data.row_start == '0 && out_data.target_node == '0 &&
		out_data.edge_index == '0)
		else $error("error result carries nonzero data");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result beat without a command beat");

	a_clear_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !in_ready)
		else $error("ready high during the clearing sweep");

endmodule

bind csr_transpose_engine_unit cte_checker u_cte_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for csr_transpose_engine_unit, directed table then random graphs
// keeps its own transpose predictor, drives random idling and a long output hold-off
// depends on cte_pkg and the csr_transpose_engine_unit rtl
`timescale 1ns / 1ps

module tb_top;
	import cte_pkg::*;

	localparam int MAX_N = MAX_NODES_DEF;
	localparam int MAX_E = MAX_EDGES_DEF;
	localparam int RUN_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int BEATS_PER_PHASE = 225;
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
	localparam int SEND_PCT [4] = '{0, 45, 0, 36};
	localparam int RECV_PCT [4] = '{0, 0, 45, 36};

	typedef struct {
		bit                is_cfg;
		logic [NC_W-1:0]   nc;
		cte_in_t           beat;
		bit                typed;
		cte_out_t          res;
	} dir_row_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_ready;
	cte_in_t         in_data = '0;
	logic            out_valid;
	logic            out_ready = 1'b0;
	cte_out_t        out_data;
	logic            cfg_wr_en = 1'b0;
	logic [NC_W-1:0] cfg_wr_data = '0;

	// predictor state
	int              row_tally [0:MAX_N];
	int              fill_at [0:MAX_N-1];
	logic [9:0]      edge_dst [0:MAX_E-1];
	logic [9:0]      edge_src [0:MAX_E-1];
	logic [9:0]      placed_tgt [0:MAX_E-1];
	logic [11:0]     placed_eid [0:MAX_E-1];
	int              edges_held = 0;
	bit              transposed = 1'b0;
	logic [NC_W-1:0] nodes_cfg = NODE_TOTAL_RST;

	cte_out_t        pending [$];
	cte_out_t        want;
	dir_row_t        dir_tab [$];
	int              errors = 0;
	int              beats_sent = 0;
	int              send_pct = 0;
	int              recv_pct = 0;
	int              hold_req = 0;
	int              hold_seen = 0;
	int              hold_left = 0;
	int unsigned     cycles = 0;

	csr_transpose_engine_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int active_nodes();
		if (nodes_cfg == '0) return 1;
		if (int'(nodes_cfg) > MAX_N) return MAX_N;
		return int'(nodes_cfg);
	endfunction

	function automatic cte_out_t predict_result(input cte_in_t b);
		cte_out_t r;
		int n, idx, p, e;
		r = '0;
		n = active_nodes();
		idx = int'(b.read_index);
		case (b.command)
			CMD_CLEAR: begin
				for (p = 0; p <= MAX_N; p++) row_tally[p] = 0;
				edges_held = 0;
				transposed = 1'b0;
			end
			CMD_LOAD: begin
				if (transposed) r.status = ST_BAD;
				else if (int'(b.dest_node) >= n || int'(b.src_node) >= n) r.status = ST_RANGE;
				else if (edges_held >= MAX_E) r.status = ST_FULL;
				else begin
					edge_dst[edges_held] = b.dest_node;
					edge_src[edges_held] = b.src_node;
					row_tally[int'(b.src_node) + 1]++;
					edges_held++;
				end
			end
			CMD_FINISH: begin
				if (!transposed) begin
					for (p = 0; p < MAX_N; p++) row_tally[p + 1] += row_tally[p];
					for (p = 0; p < MAX_N; p++) fill_at[p] = row_tally[p];
					for (e = 0; e < edges_held; e++) begin
						p = fill_at[edge_src[e]];
						fill_at[edge_src[e]]++;
						placed_tgt[p] = edge_dst[e];
						placed_eid[p] = e[11:0];
					end
					transposed = 1'b1;
				end
			end
			CMD_ROW: begin
				if (!transposed || idx > n) r.status = ST_BAD;
				else r.row_start = row_tally[idx][RS_FW-1:0];
			end
			CMD_ENTRY: begin
				if (!transposed || idx >= edges_held) r.status = ST_BAD;
				else begin
					r.target_node = placed_tgt[idx];
					r.edge_index = placed_eid[idx];
				end
			end
			default: r.status = ST_BAD;
		endcase
		return r;
	endfunction

	function automatic cte_in_t beat_of(input logic [CMD_W-1:0] c, input int d, input int s,
			input int i);
		cte_in_t b;
		b.command = c;
		b.dest_node = d[NODE_FW-1:0];
		b.src_node = s[NODE_FW-1:0];
		b.read_index = i[IDX_W-1:0];
		return b;
	endfunction

	function automatic dir_row_t cmd_row(input logic [CMD_W-1:0] c, input int d, input int s,
			input int i);
		dir_row_t r;
		r.is_cfg = 1'b0;
		r.nc = '0;
		r.beat = beat_of(c, d, s, i);
		r.typed = 1'b0;
		r.res = '0;
		return r;
	endfunction

	function automatic dir_row_t known_row(input logic [CMD_W-1:0] c, input int d, input int s,
			input int i, input logic [ST_W-1:0] st, input int rs);
		dir_row_t r;
		r = cmd_row(c, d, s, i);
		r.typed = 1'b1;
		r.res.status = st;
		r.res.row_start = rs[RS_FW-1:0];
		return r;
	endfunction

	function automatic dir_row_t cfg_row(input logic [NC_W-1:0] v);
		dir_row_t r;
		r = cmd_row(CMD_CLEAR, 0, 0, 0);
		r.is_cfg = 1'b1;
		r.nc = v;
		return r;
	endfunction

	function automatic logic [NC_W-1:0] pick_nodes_cfg();
		int unsigned sel;
		sel = $urandom_range(7);
		case (sel)
			0: return '0;
			1: return 11'd2047;
			2: return NODE_TOTAL_RST;
			3, 4: return NC_W'($urandom_range(1, 16));
			5: return NC_W'($urandom_range(1025, 2047));
			default: return NC_W'($urandom_range(17, 1024));
		endcase
	endfunction

	task automatic send_beat(input cte_in_t b, input bit typed, input cte_out_t typed_res);
		cte_out_t pred;
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pred = predict_result(b);
		if (typed) pred = typed_res;
		pending = {pending, pred};
		beats_sent++;
	endtask

	task automatic issue(input logic [CMD_W-1:0] c, input int d, input int s, input int i);
		send_beat(beat_of(c, d, s, i), 1'b0, '0);
	endtask

	task automatic write_nodes_cfg(input logic [NC_W-1:0] v);
		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		nodes_cfg = v;
	endtask

	// off-pattern beats mixed into the load stream
	task automatic stray_beat(input int n);
		int unsigned sel;
		sel = $urandom_range(3);
		if (sel == 0 && n < MAX_N) begin
			if ($urandom_range(1))
				issue(CMD_LOAD, $urandom_range(n, MAX_N - 1), $urandom_range(0, n - 1), $urandom);
			else
				issue(CMD_LOAD, $urandom_range(0, n - 1), $urandom_range(n, MAX_N - 1), $urandom);
		end else if (sel == 1) begin
			issue(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), $urandom, $urandom,
				$urandom);
		end else if (sel == 2) begin
			issue($urandom_range(1) ? CMD_ROW : CMD_ENTRY, $urandom, $urandom,
				$urandom_range(0, 8191));
		end else begin
			issue(CMD_LOAD, $urandom_range(0, n - 1), $urandom_range(0, n - 1), $urandom);
		end
	endtask

	task automatic run_graph(input int n_edges, input bit squeeze);
		int n, d, k, step, reads;
		int unsigned sel;
		n = active_nodes();
		issue(CMD_CLEAR, $urandom, $urandom, $urandom);
		d = 0;
		step = 2 * n / (n_edges + 1) + 1;
		for (k = 0; k < n_edges; k++) begin
			if ($urandom_range(99) < 8) stray_beat(n);
			if ($urandom_range(1)) d = d + $urandom_range(0, step);
			if (d > n - 1) d = n - 1;
			issue(CMD_LOAD, d, $urandom_range(0, n - 1), $urandom);
			if (squeeze && k == 0) hold_req <= hold_req + 1;
		end
		issue(CMD_FINISH, $urandom, $urandom, $urandom);
		if ($urandom_range(99) < 15) issue(CMD_FINISH, $urandom, $urandom, $urandom);
		if ($urandom_range(99) < 10)
			issue(CMD_LOAD, $urandom_range(0, n - 1), $urandom_range(0, n - 1), $urandom);
		reads = $urandom_range(4, 24);
		for (k = 0; k < reads; k++) begin
			sel = $urandom_range(9);
			if (sel == 0)
				issue($urandom_range(1) ? CMD_ROW : CMD_ENTRY, $urandom, $urandom,
					$urandom_range(0, 8191));
			else if (sel < 5)
				issue(CMD_ROW, $urandom, $urandom, $urandom_range(0, n));
			else
				issue(CMD_ENTRY, $urandom, $urandom,
					(edges_held > 0) ? $urandom_range(0, edges_held - 1) : 0);
		end
	endtask

	task automatic check_field(input string fname, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want_v, got_v);
		end
	endtask

	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected, got %h", $time, out_data);
			end else begin
				want = pending.pop_front();
				check_field("status", 32'(want.status), 32'(out_data.status));
				check_field("row_start", 32'(want.row_start), 32'(out_data.row_start));
				check_field("target_node", 32'(want.target_node), 32'(out_data.target_node));
				check_field("edge_index", 32'(want.edge_index), 32'(out_data.edge_index));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= RUN_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int mode, target;
		logic [NC_W-1:0] first_nc [4];
		first_nc = '{11'd1, 11'd0, 11'd2047, 11'd1024};
		dir_tab = '{
			known_row(CMD_ROW, 0, 0, 0, ST_BAD, 0),
			known_row(CMD_SPARE_HI, 0, 0, 0, ST_BAD, 0),
			known_row(CMD_LOAD, 0, 1023, 0, ST_OK, 0),
			cmd_row(CMD_LOAD, 1, 0, 0),
			cmd_row(CMD_LOAD, 1023, 5, 0),
			cmd_row(CMD_LOAD, 2, 5, 0),
			known_row(CMD_FINISH, 0, 0, 0, ST_OK, 0),
			known_row(CMD_FINISH, 0, 0, 0, ST_OK, 0),
			known_row(CMD_LOAD, 3, 3, 0, ST_BAD, 0),
			known_row(CMD_ROW, 0, 0, 0, ST_OK, 0),
			known_row(CMD_ROW, 0, 0, 1024, ST_OK, 4),
			known_row(CMD_ROW, 0, 0, 1025, ST_BAD, 0),
			known_row(CMD_ROW, 0, 0, 8191, ST_BAD, 0),
			cmd_row(CMD_ENTRY, 0, 0, 0),
			cmd_row(CMD_ENTRY, 0, 0, 3),
			known_row(CMD_ENTRY, 0, 0, 4, ST_BAD, 0),
			cfg_row(11'd3),
			known_row(CMD_CLEAR, 1023, 1023, 8191, ST_OK, 0),
			known_row(CMD_LOAD, 3, 0, 0, ST_RANGE, 0),
			known_row(CMD_LOAD, 0, 3, 0, ST_RANGE, 0),
			cmd_row(CMD_LOAD, 2, 2, 0),
			cmd_row(CMD_LOAD, 2, 1, 0),
			cfg_row(11'd2),
			known_row(CMD_FINISH, 0, 0, 0, ST_OK, 0),
			cmd_row(CMD_ROW, 0, 0, 2),
			known_row(CMD_ROW, 0, 0, 3, ST_BAD, 0),
			known_row(CMD_SPARE_LO, 0, 0, 0, ST_BAD, 0),
			cmd_row(CMD_ENTRY, 0, 0, 1)
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) write_nodes_cfg(dir_tab[i].nc);
			else send_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].res);
		end
		for (mode = 0; mode < 4; mode++) begin
			send_pct = SEND_PCT[mode];
			recv_pct <= RECV_PCT[mode];
			target = beats_sent + BEATS_PER_PHASE;
			write_nodes_cfg(first_nc[mode]);
			run_graph(60, mode == 0);
			while (beats_sent < target) begin
				write_nodes_cfg(pick_nodes_cfg());
				run_graph(($urandom_range(7) == 0) ? $urandom_range(80, 160) : $urandom_range(0, 40),
					1'b0);
			end
		end
		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule
